// ----- rtl/bmprle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BMP RLE8 decoder package
// Parse phases, escape and register codes, and the result request record.
// ----------------------------------------------------------------------------
package bmprle_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 8;
  localparam int ADDR_W    = 26;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [BYTE_W-1:0] ESC_END_OF_LINE  = 8'd0;
  localparam logic [BYTE_W-1:0] ESC_END_OF_IMAGE = 8'd1;
  localparam logic [BYTE_W-1:0] ESC_DELTA        = 8'd2;

  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_VALUE  = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_ABS    = 3'd3,
    PH_PAD    = 3'd4,
    PH_RIGHT  = 3'd5,
    PH_UP     = 3'd6
  } phase_e;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] pix;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/bmp_rle8_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BMP RLE8 decoder
// Turns an RLE8 byte stream into frame-buffer write run requests.
// ----------------------------------------------------------------------------
// One compressed byte is taken per cycle while the input is not stalled. A
// byte is held in the input register and parsed against the decoder state in
// a single pass; its run request and any end-of-image request enter a
// four-entry result queue and leave one per cycle while out_stall_i is low.
// Input stalls while the queue holds more than two requests. The column within
// the line is tracked alongside the linear cursor, so line ends and deltas
// need no division; after any write to image_width or image_height the input
// stalls while a serial remainder unit rebuilds the column from the cursor.
module bmp_rle8_decoder #(
  parameter int MAX_SIDE = 8192
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bmprle_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bmprle_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [bmprle_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic                              start_of_image_i,
  input  wire logic                              end_of_stream_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   out_kind_o,
  output logic [bmprle_pkg::ADDR_W-1:0]          write_address_o,
  output logic [bmprle_pkg::LEN_W-1:0]           run_length_o,
  output logic [bmprle_pkg::BYTE_W-1:0]          pixel_index_o,
  output logic                                   last_o
);

  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int CUR_W      = 2 * SIDE_W;
  localparam int TGT_W      = CUR_W + 9;
  localparam int PROD_W     = SIDE_W + 8;
  localparam int RED_W      = ((SIDE_W > 8) ? SIDE_W : 8) + 1;
  localparam int CMP_W      = RED_W + 8;
  localparam int DIV_CNT_W  = $clog2(CUR_W + 1);
  localparam int DIV_IDX_W  = $clog2(CUR_W);
  localparam int RESET_SIDE = (1024 > MAX_SIDE) ? MAX_SIDE : 1024;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [bmprle_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return SIDE_W'(v);
    end
  endfunction

  // configuration
  logic [SIDE_W-1:0]    width_q, height_q;
  logic [CUR_W-1:0]     total_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 busy;

  // input register
  logic                            in_vld_q;
  logic [bmprle_pkg::BYTE_W-1:0]   in_byte_q;
  logic                            in_sof_q, in_eos_q;
  logic                            proc;

  // decoder state
  bmprle_pkg::phase_e              phase_q, phase_n;
  logic [bmprle_pkg::BYTE_W-1:0]   held_q, held_n;
  logic [bmprle_pkg::BYTE_W-1:0]   abs_q, abs_n;
  logic                            pad_q, pad_n;
  logic [bmprle_pkg::BYTE_W-1:0]   dr_q, dr_n;
  logic [CUR_W-1:0]                cur_q, cur_n;
  logic [SIDE_W-1:0]               col_q, col_n;
  logic                            done_q, done_n;

  // result queue
  bmprle_pkg::res_t                rq_q [bmprle_pkg::RQ_DEPTH];
  logic [bmprle_pkg::RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [bmprle_pkg::RQ_CNT_W-1:0] cnt_q;
  logic [bmprle_pkg::RQ_CNT_W-1:0] npush;
  logic                            pop;
  logic                            run_v, mark_v;
  bmprle_pkg::res_t                run_r, mark_r, slot0;

  logic [SIDE_W-1:0] red_col;
  logic [SIDE_W:0]   div_r;
  logic [DIV_IDX_W-1:0] div_idx;

  assign busy       = (div_cnt_q != '0);
  assign proc       = in_vld_q && !busy && (cnt_q <= bmprle_pkg::RQ_CNT_W'(bmprle_pkg::RQ_DEPTH - 2));
  assign in_stall_o = in_vld_q && !proc;

  // column after adding a run length or delta, reduced modulo the line width
  always_comb begin
    logic [RED_W-1:0]  r;
    logic [CMP_W-1:0]  m;
    logic [bmprle_pkg::BYTE_W-1:0] addend;
    unique case (phase_q)
      bmprle_pkg::PH_VALUE: addend = held_q;
      bmprle_pkg::PH_UP:    addend = dr_q;
      default:              addend = 8'd1;
    endcase
    r = RED_W'(col_q) + RED_W'(addend);
    for (int k = 7; k >= 0; k--) begin
      m = CMP_W'(width_q) << k;
      if (CMP_W'(r) >= m) begin
        r = r - RED_W'(m);
      end
    end
    red_col = SIDE_W'(r);
  end

  // serial remainder step: cursor mod width
  always_comb begin
    div_idx = DIV_IDX_W'(div_cnt_q - DIV_CNT_W'(1));
    div_r   = {col_q, cur_q[div_idx]};
    if (div_r >= {1'b0, width_q}) begin
      div_r = div_r - {1'b0, width_q};
    end
  end

  // byte parse
  always_comb begin
    bmprle_pkg::phase_e            ph_e;
    logic [bmprle_pkg::BYTE_W-1:0] held_e, abs_e, dr_e, b;
    logic                          pad_e, done_e, in_range, clip;
    logic [CUR_W-1:0]              cur_e;
    logic [SIDE_W-1:0]             col_e;
    logic [TGT_W-1:0]              sum_held, tgt_eol, tgt_up;
    logic [PROD_W-1:0]             prod;
    logic [bmprle_pkg::LEN_W-1:0]  len;

    b      = in_byte_q;
    ph_e   = in_sof_q ? bmprle_pkg::PH_FIRST : phase_q;
    held_e = in_sof_q ? '0 : held_q;
    abs_e  = in_sof_q ? '0 : abs_q;
    pad_e  = in_sof_q ? 1'b0 : pad_q;
    dr_e   = in_sof_q ? '0 : dr_q;
    cur_e  = in_sof_q ? '0 : cur_q;
    col_e  = in_sof_q ? '0 : col_q;
    done_e = in_sof_q ? 1'b0 : done_q;

    in_range = (cur_e < total_q);
    sum_held = TGT_W'(cur_e) + TGT_W'(held_e);
    clip     = (sum_held >= TGT_W'(total_q));
    tgt_eol  = TGT_W'(cur_e) - TGT_W'(col_e) + TGT_W'(width_q);
    prod     = PROD_W'(b) * PROD_W'(width_q);
    tgt_up   = TGT_W'(cur_e) + TGT_W'(prod) + TGT_W'(dr_e);
    len      = clip ? bmprle_pkg::LEN_W'(total_q - cur_e) : held_e;

    phase_n = ph_e;
    held_n  = held_e;
    abs_n   = abs_e;
    pad_n   = pad_e;
    dr_n    = dr_e;
    cur_n   = cur_e;
    col_n   = col_e;
    done_n  = done_e;

    run_v = 1'b0;
    run_r = '{kind: bmprle_pkg::KIND_RUN, addr: bmprle_pkg::ADDR_W'(cur_e),
              len: '0, pix: b, last: 1'b0};
    mark_v = 1'b0;
    mark_r = '{kind: bmprle_pkg::KIND_MARKER, addr: '0, len: '0, pix: '0, last: 1'b1};

    if (!done_e) begin
      unique case (ph_e)
        bmprle_pkg::PH_VALUE: begin
          if (in_range && len != '0) begin
            run_v     = 1'b1;
            run_r.len = len;
            cur_n     = clip ? total_q : CUR_W'(sum_held);
            col_n     = clip ? '0 : red_col;
          end
          phase_n = bmprle_pkg::PH_FIRST;
        end
        bmprle_pkg::PH_ESCAPE: begin
          if (b == bmprle_pkg::ESC_END_OF_LINE) begin
            // a cursor already on a line start (other than 0) stays put
            if (in_range && !(col_e == '0 && cur_e != '0)) begin
              cur_n = (tgt_eol >= TGT_W'(total_q)) ? total_q : CUR_W'(tgt_eol);
              col_n = '0;
            end
            phase_n = bmprle_pkg::PH_FIRST;
          end else if (b == bmprle_pkg::ESC_END_OF_IMAGE) begin
            mark_v  = 1'b1;
            done_n  = 1'b1;
            phase_n = bmprle_pkg::PH_FIRST;
          end else if (b == bmprle_pkg::ESC_DELTA) begin
            phase_n = bmprle_pkg::PH_RIGHT;
          end else begin
            abs_n   = b;
            pad_n   = b[0];
            phase_n = bmprle_pkg::PH_ABS;
          end
        end
        bmprle_pkg::PH_ABS: begin
          if (in_range) begin
            run_v     = 1'b1;
            run_r.len = bmprle_pkg::LEN_W'(1);
            cur_n     = cur_e + CUR_W'(1);
            col_n     = red_col;
          end
          abs_n = abs_e - 8'd1;
          if (abs_n == '0) begin
            phase_n = pad_e ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
          end
        end
        bmprle_pkg::PH_PAD: begin
          pad_n   = 1'b0;
          phase_n = bmprle_pkg::PH_FIRST;
        end
        bmprle_pkg::PH_RIGHT: begin
          dr_n    = b;
          phase_n = bmprle_pkg::PH_UP;
        end
        bmprle_pkg::PH_UP: begin
          if (in_range) begin
            if (tgt_up >= TGT_W'(total_q)) begin
              cur_n = total_q;
              col_n = '0;
            end else begin
              cur_n = CUR_W'(tgt_up);
              col_n = red_col;
            end
          end
          phase_n = bmprle_pkg::PH_FIRST;
        end
        default: begin
          if (b == '0) begin
            phase_n = bmprle_pkg::PH_ESCAPE;
          end else begin
            held_n  = b;
            phase_n = bmprle_pkg::PH_VALUE;
          end
        end
      endcase
    end

    if (in_eos_q && !done_n) begin
      mark_v = 1'b1;
      done_n = 1'b1;
    end
  end

  assign slot0 = run_v ? run_r : mark_r;
  assign npush = proc ? (bmprle_pkg::RQ_CNT_W'(run_v) + bmprle_pkg::RQ_CNT_W'(mark_v)) : '0;
  assign pop   = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= SIDE_W'(RESET_SIDE);
      height_q  <= SIDE_W'(RESET_SIDE);
      total_q   <= CUR_W'(RESET_SIDE * RESET_SIDE);
      div_cnt_q <= '0;
      in_vld_q  <= 1'b0;
      phase_q   <= bmprle_pkg::PH_FIRST;
      held_q    <= '0;
      abs_q     <= '0;
      pad_q     <= 1'b0;
      dr_q      <= '0;
      cur_q     <= '0;
      col_q     <= '0;
      done_q    <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      total_q <= {{SIDE_W{1'b0}}, width_q} * {{SIDE_W{1'b0}}, height_q};

      if (cfg_we_i) begin
        if (cfg_idx_i == bmprle_pkg::REG_IMAGE_WIDTH) begin
          width_q <= clamp_side(cfg_wdata_i);
        end else begin
          height_q <= clamp_side(cfg_wdata_i);
        end
        div_cnt_q <= DIV_CNT_W'(CUR_W);
        col_q     <= '0;
      end else if (busy) begin
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
        col_q     <= SIDE_W'(div_r);
      end else if (proc) begin
        col_q <= col_n;
      end

      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end

      if (proc) begin
        phase_q <= phase_n;
        held_q  <= held_n;
        abs_q   <= abs_n;
        pad_q   <= pad_n;
        dr_q    <= dr_n;
        cur_q   <= cur_n;
        done_q  <= done_n;
      end

      wr_ptr_q <= wr_ptr_q + bmprle_pkg::RQ_PTR_W'(npush);
      rd_ptr_q <= rd_ptr_q + bmprle_pkg::RQ_PTR_W'(pop);
      cnt_q    <= cnt_q + npush - bmprle_pkg::RQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
      in_sof_q  <= start_of_image_i;
      in_eos_q  <= end_of_stream_i;
    end
    if (npush != '0) begin
      rq_q[wr_ptr_q] <= slot0;
    end
    if (npush == bmprle_pkg::RQ_CNT_W'(2)) begin
      rq_q[wr_ptr_q + bmprle_pkg::RQ_PTR_W'(1)] <= mark_r;
    end
  end

  assign out_valid_o     = (cnt_q != '0);
  assign out_kind_o      = rq_q[rd_ptr_q].kind;
  assign write_address_o = rq_q[rd_ptr_q].addr;
  assign run_length_o    = rq_q[rd_ptr_q].len;
  assign pixel_index_o   = rq_q[rd_ptr_q].pix;
  assign last_o          = rq_q[rd_ptr_q].last;

  // queue never overfills
  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bmprle_pkg::RQ_CNT_W'(bmprle_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  // tracked column stays inside the line while the cursor is in the image
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && cur_q < total_q) |-> (col_q < width_q))
    else $error("column out of line");

  // cursor only moves forward within an image
  a_cur_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !in_sof_q) |=> (cur_q >= $past(cur_q)))
    else $error("cursor moved backwards");

endmodule
`default_nettype wire

// ----- dv/tb_bmp_rle8_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE8 decoder testbench
// Streams directed and random RLE8 images through the decoder under several
// frame sizes and back-pressure patterns. Every accepted byte runs through a
// local decoder model, and each output request is checked against the oldest
// predicted run or end-of-image marker.
// ----------------------------------------------------------------------------
module tb_bmp_rle8_decoder;

  localparam int          MAX_SIDE       = 8192;
  localparam int          CFG_SETTLE     = 2 * $clog2(MAX_SIDE + 1) + 8;
  localparam int          ITEMS_PER_SIZE = 140;
  localparam int          N_SIZES        = 9;
  localparam int          HOLD_SIZE      = 6;
  localparam int          PAUSE_SIZE     = 7;
  localparam int          RX_HOLD_CYCLES = 150;
  localparam int          END_WAIT       = 20000;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam logic [7:0]  ESC_LEAD       = 8'h00;

  typedef struct {
    logic [bmprle_pkg::BYTE_W-1:0] data;
    logic                          soi;
    logic                          eos;
  } stream_byte_t;

  int unsigned size_w [N_SIZES] = '{8, 1, 0, 16383, 13, 8192, 16, 255, 1024};
  int unsigned size_h [N_SIZES] = '{4, 1, 0, 16383, 7, 8192, 3, 2, 1024};

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             cfg_we         = 1'b0;
  logic [bmprle_pkg::CFG_IDX_W-1:0] cfg_idx        = '0;
  logic [bmprle_pkg::CFG_W-1:0]     cfg_wdata      = '0;
  logic                             in_valid       = 1'b0;
  logic                             in_stall;
  logic [bmprle_pkg::BYTE_W-1:0]    data_byte      = '0;
  logic                             start_of_image = 1'b0;
  logic                             end_of_stream  = 1'b0;
  logic                             out_valid;
  logic                             out_stall      = 1'b0;
  logic                             out_kind;
  logic [bmprle_pkg::ADDR_W-1:0]    write_address;
  logic [bmprle_pkg::LEN_W-1:0]     run_length;
  logic [bmprle_pkg::BYTE_W-1:0]    pixel_index;
  logic                             last;

  stream_byte_t     byte_q [$];
  bmprle_pkg::res_t expected_writes [$];

  logic        in_taken = 1'b0;
  logic        soi_next = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 53;
  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;

  // decoder model state
  logic [bmprle_pkg::CFG_W-1:0]  width_reg  = bmprle_pkg::CFG_W'(1024);
  logic [bmprle_pkg::CFG_W-1:0]  height_reg = bmprle_pkg::CFG_W'(1024);
  bmprle_pkg::phase_e            dec_phase  = bmprle_pkg::PH_FIRST;
  logic [bmprle_pkg::BYTE_W-1:0] run_count  = '0;
  logic [bmprle_pkg::BYTE_W-1:0] abs_left   = '0;
  logic                          pad_due    = 1'b0;
  logic [bmprle_pkg::BYTE_W-1:0] skip_right = '0;
  logic [26:0]                   cursor     = '0;
  logic                          img_done   = 1'b0;

  bmp_rle8_decoder #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .start_of_image_i(start_of_image),
    .end_of_stream_i (end_of_stream),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_kind_o      (out_kind),
    .write_address_o (write_address),
    .run_length_o    (run_length),
    .pixel_index_o   (pixel_index),
    .last_o          (last)
  );

  always #5ns clk_i = ~clk_i;

  function automatic longint unsigned clamp_side(logic [bmprle_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic logic [26:0] saturate(longint unsigned target, longint unsigned total);
    return (target < total) ? target[26:0] : total[26:0];
  endfunction

  function automatic void expect_request(logic kind, logic [bmprle_pkg::ADDR_W-1:0] addr,
                                         logic [bmprle_pkg::LEN_W-1:0] len,
                                         logic [bmprle_pkg::BYTE_W-1:0] pix);
    bmprle_pkg::res_t r;
    r.kind = kind;
    r.addr = addr;
    r.len  = len;
    r.pix  = pix;
    r.last = kind;
    expected_writes.insert(expected_writes.size(), r);
  endfunction

  function automatic void decode_byte(logic [bmprle_pkg::BYTE_W-1:0] b, logic soi, logic eos);
    longint unsigned total, w, len, line, col;
    if (soi) begin
      dec_phase  = bmprle_pkg::PH_FIRST;
      run_count  = '0;
      abs_left   = '0;
      pad_due    = 1'b0;
      skip_right = '0;
      cursor     = '0;
      img_done   = 1'b0;
    end
    w     = clamp_side(width_reg);
    total = w * clamp_side(height_reg);
    if (!img_done) begin
      case (dec_phase)
        bmprle_pkg::PH_VALUE: begin
          if (cursor < total) begin
            len = total - cursor;
            if (len > run_count) len = run_count;
            if (len != 0) begin
              expect_request(bmprle_pkg::KIND_RUN, cursor[bmprle_pkg::ADDR_W-1:0],
                             len[bmprle_pkg::LEN_W-1:0], b);
              cursor = saturate(cursor + len, total);
            end
          end
          dec_phase = bmprle_pkg::PH_FIRST;
        end
        bmprle_pkg::PH_ESCAPE: begin
          if (b == bmprle_pkg::ESC_END_OF_LINE) begin
            if (cursor < total) begin
              line   = (cursor == 0) ? 0 : (cursor - 1) / w;
              cursor = saturate((line + 1) * w, total);
            end
            dec_phase = bmprle_pkg::PH_FIRST;
          end else if (b == bmprle_pkg::ESC_END_OF_IMAGE) begin
            expect_request(bmprle_pkg::KIND_MARKER, '0, '0, '0);
            img_done  = 1'b1;
            dec_phase = bmprle_pkg::PH_FIRST;
          end else if (b == bmprle_pkg::ESC_DELTA) begin
            dec_phase = bmprle_pkg::PH_RIGHT;
          end else begin
            abs_left  = b;
            pad_due   = b[0];
            dec_phase = bmprle_pkg::PH_ABS;
          end
        end
        bmprle_pkg::PH_ABS: begin
          if (cursor < total) begin
            expect_request(bmprle_pkg::KIND_RUN, cursor[bmprle_pkg::ADDR_W-1:0],
                           bmprle_pkg::LEN_W'(1), b);
            cursor = saturate(cursor + 1, total);
          end
          abs_left = abs_left - 1'b1;
          if (abs_left == '0) begin
            dec_phase = pad_due ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
          end
        end
        bmprle_pkg::PH_PAD: begin
          pad_due   = 1'b0;
          dec_phase = bmprle_pkg::PH_FIRST;
        end
        bmprle_pkg::PH_RIGHT: begin
          skip_right = b;
          dec_phase  = bmprle_pkg::PH_UP;
        end
        bmprle_pkg::PH_UP: begin
          if (cursor < total) begin
            line   = cursor / w;
            col    = cursor - line * w;
            cursor = saturate((line + b) * w + col + skip_right, total);
          end
          dec_phase = bmprle_pkg::PH_FIRST;
        end
        default: begin
          if (b == ESC_LEAD) begin
            dec_phase = bmprle_pkg::PH_ESCAPE;
          end else begin
            run_count = b;
            dec_phase = bmprle_pkg::PH_VALUE;
          end
        end
      endcase
    end
    if (eos && !img_done) begin
      expect_request(bmprle_pkg::KIND_MARKER, '0, '0, '0);
      img_done = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void queue_byte(logic [bmprle_pkg::BYTE_W-1:0] b, logic eos = 1'b0);
    stream_byte_t s;
    s.data = b;
    s.soi  = soi_next;
    s.eos  = eos;
    soi_next = 1'b0;
    byte_q.insert(byte_q.size(), s);
    n_pushed++;
  endfunction

  function automatic void build_image(int unsigned n_cmds);
    int unsigned r, n;
    soi_next = 1'b1;
    for (int i = 0; i < n_cmds; i++) begin
      if ($urandom_range(99) < 3) soi_next = 1'b1;
      r = $urandom_range(99);
      if (r < 40) begin
        queue_byte(bmprle_pkg::BYTE_W'($urandom_range(1) ? $urandom_range(1, 15)
                                                         : $urandom_range(1, 255)));
        queue_byte(bmprle_pkg::BYTE_W'($urandom_range(255)));
      end else if (r < 60) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(13, 255) : $urandom_range(3, 12);
        queue_byte(ESC_LEAD);
        queue_byte(bmprle_pkg::BYTE_W'(n));
        repeat (n) queue_byte(bmprle_pkg::BYTE_W'($urandom_range(255)));
        if (n[0]) queue_byte(bmprle_pkg::BYTE_W'($urandom_range(255)));
      end else if (r < 72) begin
        queue_byte(ESC_LEAD);
        queue_byte(bmprle_pkg::ESC_END_OF_LINE);
      end else if (r < 85) begin
        queue_byte(ESC_LEAD);
        queue_byte(bmprle_pkg::ESC_DELTA);
        queue_byte(bmprle_pkg::BYTE_W'($urandom_range(255)));
        queue_byte(bmprle_pkg::BYTE_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                                : $urandom_range(2)));
      end else begin
        repeat ($urandom_range(1, 3)) queue_byte(bmprle_pkg::BYTE_W'($urandom_range(255)));
      end
    end
    r = $urandom_range(99);
    if (r < 50) begin
      queue_byte(ESC_LEAD);
      queue_byte(bmprle_pkg::ESC_END_OF_IMAGE);
      if ($urandom_range(4) == 0) queue_byte(bmprle_pkg::BYTE_W'($urandom_range(255)));
    end else if (r < 85 && byte_q.size() != 0) begin
      byte_q[byte_q.size() - 1].eos = 1'b1;
    end
  endfunction

  task automatic write_reg(logic [bmprle_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[bmprle_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_frame_size(int unsigned w, int unsigned h);
    write_reg(bmprle_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bmprle_pkg::REG_IMAGE_HEIGHT, h);
    n_settings++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (n_accepted != n_pushed || expected_writes.size() != 0) @(negedge clk_i);
  endtask

  // input byte driver
  always @(negedge clk_i) begin : driver
    stream_byte_t cur;
    if (!in_valid || in_taken) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = byte_q.pop_front();
        in_valid       <= 1'b1;
        data_byte      <= cur.data;
        start_of_image <= cur.soi;
        end_of_stream  <= cur.eos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, with an occasional long hold
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= RX_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    bmprle_pkg::res_t want;
    in_taken <= in_valid && !in_stall;
    if (cfg_we) begin
      if (cfg_idx == bmprle_pkg::REG_IMAGE_WIDTH) width_reg = cfg_wdata;
      else if (cfg_idx == bmprle_pkg::REG_IMAGE_HEIGHT) height_reg = cfg_wdata;
    end
    if (in_valid && !in_stall) begin
      decode_byte(data_byte, start_of_image, end_of_stream);
      n_accepted++;
    end
    if (out_valid && !out_stall) begin
      n_results++;
      if (expected_writes.size() == 0) begin
        $error("unexpected request: kind %0d addr %0d len %0d pix %0d last %0d",
               out_kind, write_address, run_length, pixel_index, last);
        n_errors++;
      end else begin
        want = expected_writes.pop_front();
        check_field("out_kind", want.kind, out_kind);
        check_field("write_address", want.addr, write_address);
        check_field("run_length", want.len, run_length);
        check_field("pixel_index", want.pix, pixel_index);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding",
               cycle_count, expected_writes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int guard;
    int unsigned target;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    set_frame_size(8, 4);
    // directed: 8x4 frame, 32 pixels
    soi_next = 1'b1;
    queue_byte(8'h05);
    queue_byte(8'h07);
    // odd absolute run, pad byte skipped
    queue_byte(ESC_LEAD);
    queue_byte(8'h03);
    queue_byte(8'hA0);
    queue_byte(8'h5F);
    queue_byte(8'hFF);
    queue_byte(8'hC3);
    // line end with the cursor already at a line start
    queue_byte(ESC_LEAD);
    queue_byte(bmprle_pkg::ESC_END_OF_LINE);
    // delta past the line end wraps into the next line
    queue_byte(ESC_LEAD);
    queue_byte(bmprle_pkg::ESC_DELTA);
    queue_byte(8'h0A);
    queue_byte(8'h01);
    // run clipped at the frame end, then one fully dropped
    queue_byte(8'hFF);
    queue_byte(8'h55);
    queue_byte(8'h04);
    queue_byte(8'h11);
    queue_byte(ESC_LEAD);
    queue_byte(bmprle_pkg::ESC_END_OF_IMAGE);
    // ignored after the image ended
    queue_byte(8'h09, 1'b1);
    // line end at pixel 0, then run plus end-of-stream marker
    soi_next = 1'b1;
    queue_byte(ESC_LEAD);
    queue_byte(bmprle_pkg::ESC_END_OF_LINE);
    queue_byte(8'h03);
    queue_byte(8'h44, 1'b1);
    wait_drained();

    for (int k = 0; k < N_SIZES; k++) begin
      if (k < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 53;
      end else if (k < 6) begin
        send_idle_pct = 53;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_frame_size(size_w[k], size_h[k]);
      if (k == PAUSE_SIZE) begin
        // sender stops between count and value until all is drained
        soi_next = 1'b1;
        queue_byte(8'h06);
        wait_drained();
        queue_byte(8'h9A);
      end
      target = n_pushed + ITEMS_PER_SIZE;
      while (n_pushed < target) build_image($urandom_range(4, 30));
      if (k == HOLD_SIZE) begin
        @(posedge clk_i);
        hold_req = ~hold_req;
      end
      wait_drained();
    end

    guard = 0;
    while ((n_accepted != n_pushed || expected_writes.size() != 0) && guard < END_WAIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (CFG_SETTLE) @(negedge clk_i);
    if (expected_writes.size() != 0) begin
      $error("%0d expected requests never arrived", expected_writes.size());
      n_errors++;
    end
    $display("Checked %0d run/marker requests decoded from %0d stream bytes",
             n_results, n_accepted);
    $display("Frame sizes: %0d incl. clamped extremes; idle, stall and long-hold patterns",
             n_settings);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bmprle_pkg.sv
rtl/bmp_rle8_decoder.sv
dv/tb_bmp_rle8_decoder.sv
